/* hw/rtl/eoba_pkg.sv */
// Package with shared types and constants for the exon overlap base accumulator.
`timescale 1ns / 1ps
package eoba_pkg;
   localparam int MaxEntries = 4096;
   localparam int IdxW = $clog2(MaxEntries);
   localparam int CntW = IdxW + 1;
   localparam int QueueDepth = 2;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_QUERY = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type           command;
      logic [IdxW-1:0]   entry_index;
      logic              index_ok;
      logic [31:0]       start_pos;
      logic [31:0]       end_pos;
      logic [CntW-1:0]   active;
   } work_type;
endpackage

/* hw/rtl/exon_overlap_base_accumulator.sv */
// Top level of the exon overlap base accumulator.
//
//   Channel  | Ports                                    | Handshake
//   request  | req_command/entry_index/start_pos/end_pos| start high and busy low
//   response | rsp_hit/hit_index/entries_updated/read_count | rsp_valid, one cycle
//   config   | csr_ APB-style, entry_count at address 0 | psel&penable&pwrite
//
// A load writes the tables when taken; a read waits for the RAM and registers its data.
// A query takes address, RAM read wait and compare steps per binary-search probe, in up
// to two searches of about twelve probes, plus address, wait, check and update steps per
// walked neighbor; all of it is bound by the single RAM port. Reset clears control state
// and entry_count; the tables are undefined until loaded. A two-item queue sits between
// the command front and the execution back, so a new item can be taken while one is
// running. The receiver cannot stall: rsp_valid is a single-cycle strobe.
`timescale 1ns / 1ps
module exon_overlap_base_accumulator (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_command,
   input  logic [eoba_pkg::IdxW-1:0]  req_entry_index,
   input  logic [31:0]                req_start_pos,
   input  logic [31:0]                req_end_pos,
   output logic                       rsp_valid,
   output logic                       rsp_hit,
   output logic [eoba_pkg::IdxW-1:0]  rsp_hit_index,
   output logic [eoba_pkg::CntW-1:0]  rsp_entries_updated,
   output logic [31:0]                rsp_read_count,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic                       csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);
   logic [eoba_pkg::CntW-1:0] entry_count_ff;
   logic work_valid, work_take;
   eoba_pkg::work_type work;

   // Only one register; the single address bit must be zero for a hit.
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr ? 32'd0 : 32'(entry_count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && !csr_paddr) begin
         entry_count_ff <= csr_pwdata[eoba_pkg::CntW-1:0];
      end
   end

   eoba_front u_front (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_entry_index(req_entry_index),
      .req_start_pos(req_start_pos), .req_end_pos(req_end_pos),
      .entry_count(entry_count_ff), .work_valid(work_valid), .work(work),
      .work_take(work_take));

   eoba_back u_back (
      .clock(clock), .reset(reset), .work_valid(work_valid), .work(work),
      .work_take(work_take), .done(rsp_valid), .rsp_hit(rsp_hit),
      .rsp_hit_index(rsp_hit_index), .rsp_entries_updated(rsp_entries_updated),
      .rsp_read_count(rsp_read_count));
endmodule

/* hw/rtl/eoba_ram.sv */
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
module eoba_ram #(
   parameter int Width = 32,
   parameter int Depth = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

/* hw/rtl/eoba_front.sv */
// Front end: accepts commands, clamps the entry count and queues work items.
`timescale 1ns / 1ps
module eoba_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_command,
   input  logic [eoba_pkg::IdxW-1:0]  req_entry_index,
   input  logic [31:0]                req_start_pos,
   input  logic [31:0]                req_end_pos,
   input  logic [eoba_pkg::CntW-1:0]  entry_count,
   output logic                       work_valid,
   output eoba_pkg::work_type         work,
   input  logic                       work_take
);
   eoba_pkg::work_type q_ff [eoba_pkg::QueueDepth];
   logic [1:0] fill_ff, fill_in;
   logic       push;
   eoba_pkg::work_type item;

   always_comb begin
      item.command     = eoba_pkg::cmd_type'(req_command);
      item.entry_index = req_entry_index;
      item.index_ok    = 1'b1;
      item.start_pos   = req_start_pos;
      item.end_pos     = req_end_pos;
      item.active      = (entry_count > eoba_pkg::CntW'(eoba_pkg::MaxEntries)) ?
                         eoba_pkg::CntW'(eoba_pkg::MaxEntries) : entry_count;
   end

   assign busy       = (fill_ff == 2'(eoba_pkg::QueueDepth));
   assign push       = start && !busy;
   assign work_valid = (fill_ff != 2'd0);
   assign work       = q_ff[0];

   always_comb begin
      fill_in = fill_ff + 2'(push) - 2'(work_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= 2'd0;
      end else begin
         fill_ff <= fill_in;
      end
      if (work_take) begin
         q_ff[0] <= (push && fill_ff == 2'd1) ? item : q_ff[1];
      end else if (push && fill_ff == 2'd0) begin
         q_ff[0] <= item;
      end
      if (push && ((fill_ff == 2'd1 && !work_take) || (fill_ff == 2'd2))) begin
         q_ff[1] <= item;
      end
   end
endmodule

/* hw/rtl/eoba_back.sv */
// Back end: runs loads, reads and the search-and-walk of a query over the RAMs.
`timescale 1ns / 1ps
module eoba_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        work_valid,
   input  eoba_pkg::work_type          work,
   output logic                        work_take,
   output logic                        done,
   output logic                        rsp_hit,
   output logic [eoba_pkg::IdxW-1:0]   rsp_hit_index,
   output logic [eoba_pkg::CntW-1:0]   rsp_entries_updated,
   output logic [31:0]                 rsp_read_count
);
   localparam int IdxW = eoba_pkg::IdxW;
   localparam int CntW = eoba_pkg::CntW;

   typedef enum logic [3:0] {
      S_IDLE, S_SRCH, S_SWAIT, S_SCHK, S_RWAIT, S_RDONE,
      S_FADDR, S_FWAIT, S_FCHK, S_UPD, S_OUT
   } state_type;

   state_type state_ff;
   eoba_pkg::work_type w_ff;
   logic signed [CntW:0] lo_ff, hi_ff;
   logic second_ff, back_ff;
   logic [IdxW-1:0] addr_ff, found_ff;
   logic [CntW-1:0] cnt_ff;
   logic done_ff, hit_ff;
   logic [31:0] rc_ff;

   logic we_pos, we_cnt;
   logic [31:0] es, ee, cv, cnt_wdata;
   logic [31:0] pos;
   logic signed [CntW:0] mid;
   logic holds_s, holds_e, holds_p;
   logic [32:0] len;
   logic        len_ok;
   logic [32:0] sum;

   assign pos = second_ff ? w_ff.end_pos : w_ff.start_pos;
   assign mid = (lo_ff + hi_ff) >>> 1;
   assign holds_s = (es <= w_ff.start_pos) && (w_ff.start_pos < ee);
   assign holds_e = (es <= w_ff.end_pos) && (w_ff.end_pos < ee);
   assign holds_p = second_ff ? holds_e : holds_s;

   always_comb begin
      len = 33'd0;
      len_ok = 1'b1;
      if (w_ff.start_pos <= es && ee <= w_ff.end_pos) begin
         len = {1'b0, ee} - {1'b0, es} + 33'd1;
      end else if (es <= w_ff.start_pos && w_ff.end_pos <= ee) begin
         len_ok = (w_ff.end_pos >= w_ff.start_pos);
         len = {1'b0, w_ff.end_pos} - {1'b0, w_ff.start_pos} + 33'd1;
      end else if (es <= w_ff.end_pos && w_ff.end_pos <= ee) begin
         len = {1'b0, w_ff.end_pos} - {1'b0, es} + 33'd1;
      end else if (es <= w_ff.start_pos && w_ff.start_pos <= ee) begin
         len = {1'b0, ee} - {1'b0, w_ff.start_pos} + 33'd1;
      end else begin
         len_ok = 1'b0;
      end
      sum = {1'b0, cv} + len;
   end

   assign we_pos = (state_ff == S_IDLE) && work_valid && work.command == eoba_pkg::CMD_LOAD;
   assign we_cnt = we_pos || (state_ff == S_UPD && len_ok);
   assign cnt_wdata = we_pos ? 32'd0 : (sum[32] ? 32'hFFFF_FFFF : sum[31:0]);
   assign work_take = (state_ff == S_IDLE) && work_valid;

   logic [IdxW-1:0] ram_addr;
   always_comb begin
      ram_addr = addr_ff;
      if (state_ff == S_IDLE) begin
         ram_addr = work.entry_index;
      end
   end

   eoba_ram #(.Width(32), .Depth(eoba_pkg::MaxEntries)) u_start (
      .clock(clock), .we(we_pos), .addr(ram_addr), .wdata(work.start_pos), .rdata(es));
   eoba_ram #(.Width(32), .Depth(eoba_pkg::MaxEntries)) u_end (
      .clock(clock), .we(we_pos), .addr(ram_addr), .wdata(work.end_pos), .rdata(ee));
   eoba_ram #(.Width(32), .Depth(eoba_pkg::MaxEntries)) u_count (
      .clock(clock), .we(we_cnt), .addr(ram_addr), .wdata(cnt_wdata), .rdata(cv));

   assign done                = done_ff;
   assign rsp_hit             = hit_ff;
   assign rsp_hit_index       = found_ff;
   assign rsp_entries_updated = cnt_ff;
   assign rsp_read_count      = rc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (work_valid) begin
                  w_ff      <= work;
                  hit_ff    <= 1'b0;
                  found_ff  <= '0;
                  cnt_ff    <= '0;
                  rc_ff     <= '0;
                  second_ff <= 1'b0;
                  back_ff   <= 1'b0;
                  // A read keeps its entry on the RAM address while the data settles.
                  addr_ff   <= work.entry_index;
                  lo_ff     <= '0;
                  hi_ff     <= (CntW+1)'($signed({1'b0, work.active}) - 1);
                  case (work.command)
                     eoba_pkg::CMD_QUERY: state_ff <= S_SRCH;
                     eoba_pkg::CMD_READ:  state_ff <= S_RWAIT;
                     default:             state_ff <= S_OUT;
                  endcase
               end
            end
            S_RWAIT: state_ff <= S_RDONE;
            S_RDONE: begin
               rc_ff    <= cv;
               state_ff <= S_OUT;
            end
            S_SRCH: begin
               if (lo_ff > hi_ff) begin
                  if (!second_ff && w_ff.start_pos < w_ff.end_pos) begin
                     second_ff <= 1'b1;
                     lo_ff     <= '0;
                     hi_ff     <= (CntW+1)'($signed({1'b0, w_ff.active}) - 1);
                  end else begin
                     state_ff <= S_OUT;
                  end
               end else begin
                  addr_ff  <= mid[IdxW-1:0];
                  state_ff <= S_SWAIT;
               end
            end
            S_SWAIT: state_ff <= S_SCHK;
            S_SCHK: begin
               if (holds_p) begin
                  hit_ff   <= 1'b1;
                  found_ff <= addr_ff;
                  state_ff <= S_FWAIT;
               end else begin
                  if (es <= pos) begin
                     lo_ff <= (CntW+1)'($signed({2'b0, addr_ff}) + 1);
                  end else begin
                     hi_ff <= (CntW+1)'($signed({2'b0, addr_ff}) - 1);
                  end
                  state_ff <= S_SRCH;
               end
            end
            S_FADDR: state_ff <= S_FWAIT;
            S_FWAIT: state_ff <= S_FCHK;
            S_FCHK: begin
               if (addr_ff == found_ff && !back_ff) begin
                  state_ff <= S_UPD;
               end else if (holds_s || holds_e) begin
                  state_ff <= S_UPD;
               end else if (!back_ff) begin
                  back_ff <= 1'b1;
                  if (found_ff == '0) begin
                     state_ff <= S_OUT;
                  end else begin
                     addr_ff  <= found_ff - 1'b1;
                     state_ff <= S_FADDR;
                  end
               end else begin
                  state_ff <= S_OUT;
               end
            end
            S_UPD: begin
               if (len_ok) begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
               if (!back_ff) begin
                  if ({1'b0, addr_ff} + 1'b1 < w_ff.active) begin
                     addr_ff  <= addr_ff + 1'b1;
                     state_ff <= S_FADDR;
                  end else begin
                     back_ff <= 1'b1;
                     if (found_ff == '0) begin
                        state_ff <= S_OUT;
                     end else begin
                        addr_ff  <= found_ff - 1'b1;
                        state_ff <= S_FADDR;
                     end
                  end
               end else if (addr_ff == '0) begin
                  state_ff <= S_OUT;
               end else begin
                  addr_ff  <= addr_ff - 1'b1;
                  state_ff <= S_FADDR;
               end
            end
            S_OUT: begin
               done_ff  <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the exon overlap base accumulator.
`timescale 1ns / 1ps
module tb_top;
   localparam int IdxW = eoba_pkg::IdxW;
   localparam int CntW = eoba_pkg::CntW;
   localparam int MaxEntries = eoba_pkg::MaxEntries;

   // Address of the single register; paddr is one bit wide.
   localparam logic ENTRY_COUNT_ADDR = 1'b0;
   // Cycles without any accepted item, result or register write before giving up.
   localparam int STALL_LIMIT = 20000;
   localparam int NUM_SMALL_TABLES = 6;
   // Entries filled with wide exons; reads and the large searches stay inside them.
   localparam int FILL_ENTRIES = 128;

   typedef struct packed {
      logic              hit;
      logic [IdxW-1:0]   hit_index;
      logic [CntW-1:0]   entries_updated;
      logic [31:0]       read_count;
   } overlap_rsp_type;

   // One row of the directed table. A row either writes entry_count or sends an item;
   // where typed is set, the expected result is the one given in the row.
   typedef struct packed {
      logic              is_cfg;
      logic [CntW-1:0]   cfg_value;
      eoba_pkg::cmd_type command;
      logic [IdxW-1:0]   entry_index;
      logic [31:0]       start_pos;
      logic [31:0]       end_pos;
      logic              typed;
      overlap_rsp_type   want;
   } directed_row_type;

   localparam overlap_rsp_type NO_RESULT = '{1'b0, '0, '0, 32'd0};

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [1:0]          req_command = eoba_pkg::CMD_NONE;
   logic [IdxW-1:0]     req_entry_index = '0;
   logic [31:0]         req_start_pos = '0;
   logic [31:0]         req_end_pos = '0;
   logic                rsp_valid;
   logic                rsp_hit;
   logic [IdxW-1:0]     rsp_hit_index;
   logic [CntW-1:0]     rsp_entries_updated;
   logic [31:0]         rsp_read_count;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic                csr_paddr = ENTRY_COUNT_ADDR;
   logic [31:0]         csr_pwdata = '0;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   // Shadow copy of the block's tables, kept by the predictor, and of its register.
   logic [31:0]         exon_lo [MaxEntries];
   logic [31:0]         exon_hi [MaxEntries];
   logic [31:0]         low_cov_bases [MaxEntries];
   logic [CntW-1:0]     shadow_entry_count;

   overlap_rsp_type     awaited_rsp[$];
   int                  fail_count = 0;
   int                  quiet_cycles = 0;
   bit                  no_gaps = 1'b0;

   directed_row_type directed_rows [22] = '{
      // Empty table: with entry_count still zero after reset a query finds nothing.
      '{1'b0, '0, eoba_pkg::CMD_QUERY, 12'd0, 32'd10, 32'd20, 1'b1, NO_RESULT},
      // The unused command changes nothing and returns all zero, even at the extremes.
      '{1'b0, '0, eoba_pkg::CMD_NONE, 12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
        NO_RESULT},
      '{1'b0, '0, eoba_pkg::CMD_LOAD, 12'd0, 32'd0, 32'hFFFF_FFFF, 1'b1, NO_RESULT},
      '{1'b0, '0, eoba_pkg::CMD_READ, 12'd0, 32'd0, 32'd0, 1'b1, NO_RESULT},
      '{1'b1, 13'd1, eoba_pkg::CMD_NONE, '0, '0, '0, 1'b0, NO_RESULT},
      // The whole 32-bit range overlaps by 2^32 bases, so the counter saturates at once.
      '{1'b0, '0, eoba_pkg::CMD_QUERY, 12'd0, 32'd0, 32'hFFFF_FFFF, 1'b1,
        '{1'b1, 12'd0, 13'd1, 32'd0}},
      '{1'b0, '0, eoba_pkg::CMD_READ, 12'd0, 32'd0, 32'd0, 1'b1,
        '{1'b0, 12'd0, 13'd0, 32'hFFFF_FFFF}},
      '{1'b0, '0, eoba_pkg::CMD_QUERY, 12'd0, 32'd5, 32'd10, 1'b0, NO_RESULT},
      '{1'b0, '0, eoba_pkg::CMD_READ, 12'd0, 32'd0, 32'd0, 1'b0, NO_RESULT},
      // A small table whose neighbors overlap, so queries walk both ways.
      '{1'b0, '0, eoba_pkg::CMD_LOAD, 12'd0, 32'd100, 32'd200, 1'b1, NO_RESULT},
      '{1'b0, '0, eoba_pkg::CMD_LOAD, 12'd1, 32'd150, 32'd300, 1'b1, NO_RESULT},
      '{1'b0, '0, eoba_pkg::CMD_LOAD, 12'd2, 32'd250, 32'd400, 1'b1, NO_RESULT},
      '{1'b0, '0, eoba_pkg::CMD_LOAD, 12'd3, 32'd500, 32'd600, 1'b1, NO_RESULT},
      '{1'b1, 13'd4, eoba_pkg::CMD_NONE, '0, '0, '0, 1'b0, NO_RESULT},
      '{1'b0, '0, eoba_pkg::CMD_QUERY, 12'd0, 32'd160, 32'd170, 1'b0, NO_RESULT},
      // Reversed interval: the start is found but the overlap is not positive.
      '{1'b0, '0, eoba_pkg::CMD_QUERY, 12'd0, 32'd590, 32'd550, 1'b0, NO_RESULT},
      // The start misses and the second search finds the stop.
      '{1'b0, '0, eoba_pkg::CMD_QUERY, 12'd0, 32'd50, 32'd120, 1'b0, NO_RESULT},
      '{1'b0, '0, eoba_pkg::CMD_QUERY, 12'd0, 32'd410, 32'd450, 1'b1, NO_RESULT},
      '{1'b0, '0, eoba_pkg::CMD_QUERY, 12'd0, 32'd399, 32'd500, 1'b0, NO_RESULT},
      '{1'b0, '0, eoba_pkg::CMD_READ, 12'd1, 32'd0, 32'd0, 1'b0, NO_RESULT},
      '{1'b0, '0, eoba_pkg::CMD_LOAD, 12'hFFF, 32'hFFFF_FFFF, 32'd0, 1'b1, NO_RESULT},
      '{1'b0, '0, eoba_pkg::CMD_READ, 12'hFFF, 32'd0, 32'd0, 1'b1, NO_RESULT}
   };

   exon_overlap_base_accumulator u_top (.*);

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------------
   // Predictor of the block.
   // ---------------------------------------------------------------------------------

   function automatic int searched_entries();
      return (shadow_entry_count > MaxEntries) ? MaxEntries : int'(shadow_entry_count);
   endfunction

   // Half-open containment: the exon holds pos if its start <= pos < its end.
   function automatic bit exon_holds(int idx, logic [31:0] pos);
      return exon_lo[idx] <= pos && pos < exon_hi[idx];
   endfunction

   // Binary search over the active entries; -1 when no probe holds pos.
   function automatic int find_exon(logic [31:0] pos);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = searched_entries() - 1;
      while (lo <= hi) begin
         mid = (lo + hi) / 2;
         if (exon_holds(mid, pos)) return mid;
         if (exon_lo[mid] <= pos) lo = mid + 1;
         else hi = mid - 1;
      end
      return -1;
   endfunction

   // Adds the inclusive overlap of [qs, qe] to one exon's counter, with saturation.
   // Returns 1 when the counter was incremented.
   function automatic int add_overlap(int idx, logic [31:0] qs_in, logic [31:0] qe_in);
      longint es;
      longint ee;
      longint qs;
      longint qe;
      longint len;
      longint sum;
      es = longint'(exon_lo[idx]);
      ee = longint'(exon_hi[idx]);
      qs = longint'(qs_in);
      qe = longint'(qe_in);
      if (qs <= es && ee <= qe) len = ee - es + 1;
      else if (es <= qs && qe <= ee) len = qe - qs + 1;
      else if (es <= qe && qe <= ee) len = qe - es + 1;
      else if (es <= qs && qs <= ee) len = ee - qs + 1;
      else return 0;
      if (len <= 0) return 0;
      sum = longint'(low_cov_bases[idx]) + len;
      if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
      low_cov_bases[idx] = sum[31:0];
      return 1;
   endfunction

   // Applies one item to the shadow state and returns the result it causes.
   function automatic overlap_rsp_type predict_overlap(eoba_pkg::cmd_type command,
                                                       logic [IdxW-1:0] idx,
                                                       logic [31:0] s, logic [31:0] e);
      overlap_rsp_type r;
      int found;
      int n;
      int updated;
      r = NO_RESULT;
      case (command)
         eoba_pkg::CMD_LOAD: begin
            exon_lo[idx] = s;
            exon_hi[idx] = e;
            low_cov_bases[idx] = '0;
         end
         eoba_pkg::CMD_READ: begin
            r.read_count = low_cov_bases[idx];
         end
         eoba_pkg::CMD_QUERY: begin
            found = find_exon(s);
            if (found < 0 && s < e) found = find_exon(e);
            if (found >= 0) begin
               n = searched_entries();
               updated = add_overlap(found, s, e);
               // Forward walk, then backward walk that stops at entry zero.
               for (int i = found + 1; i < n; i++) begin
                  if (!(exon_holds(i, s) || exon_holds(i, e))) break;
                  updated += add_overlap(i, s, e);
               end
               for (int i = found; i > 0; i--) begin
                  if (!(exon_holds(i - 1, s) || exon_holds(i - 1, e))) break;
                  updated += add_overlap(i - 1, s, e);
               end
               r.hit = 1'b1;
               r.hit_index = found[IdxW-1:0];
               r.entries_updated = updated[CntW-1:0];
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------------------------
   // Stimulus.
   // ---------------------------------------------------------------------------------

   // Presents one item, with a random gap first unless no_gaps is set, and waits until it is taken. The
   // expectation is recorded at the edge that accepts the item.
   task automatic send_item(eoba_pkg::cmd_type command, logic [IdxW-1:0] idx,
                            logic [31:0] s, logic [31:0] e, bit typed,
                            overlap_rsp_type want);
      overlap_rsp_type predicted;
      if (!no_gaps) begin
         while ($urandom_range(0, 99) < 24) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start <= 1'b1;
      req_command <= command;
      req_entry_index <= idx;
      req_start_pos <= s;
      req_end_pos <= e;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = predict_overlap(command, idx, s, e);
      awaited_rsp.push_back(typed ? want : predicted);
   endtask

   // entry_count is written only once every expected result has come back.
   task automatic write_entry_count(logic [CntW-1:0] value);
      start <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= ENTRY_COUNT_ADDR;
      csr_pwdata <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      shadow_entry_count = value;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // A random item that mostly targets stored exons, so searches hit and walks run.
   // Reads and reloads stay among the first span_entries entries, which are all loaded.
   task automatic send_random_item(int span_entries);
      int k;
      int pick;
      logic [31:0] s;
      logic [31:0] e;
      k = $urandom_range(0, span_entries - 1);
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         send_item(eoba_pkg::CMD_READ, IdxW'($urandom_range(0, span_entries - 1)),
                   $urandom, $urandom, 1'b0, NO_RESULT);
      end else if (pick < 16) begin
         send_item(eoba_pkg::CMD_NONE, IdxW'($urandom), $urandom, $urandom, 1'b0,
                   NO_RESULT);
      end else if (pick < 20) begin
         // A reload breaks the sort order now and then; searches still follow their probes.
         s = exon_lo[k] + 32'($urandom_range(0, 40)) - 32'd20;
         send_item(eoba_pkg::CMD_LOAD, IdxW'(k), s, s + 32'($urandom_range(0, 300)), 1'b0,
                   NO_RESULT);
      end else if (pick < 28) begin
         send_item(eoba_pkg::CMD_QUERY, IdxW'($urandom), $urandom, $urandom, 1'b0,
                   NO_RESULT);
      end else begin
         s = exon_lo[k] + 32'($urandom_range(0, 400)) - 32'd50;
         if ($urandom_range(0, 9) == 0) e = s - 32'($urandom_range(0, 100));
         else e = s + 32'($urandom_range(0, 700));
         send_item(eoba_pkg::CMD_QUERY, IdxW'($urandom), s, e, 1'b0, NO_RESULT);
      end
   endtask

   initial begin
      logic [31:0] s;
      int n;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      shadow_entry_count = '0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_cfg) write_entry_count(directed_rows[i].cfg_value);
         else send_item(directed_rows[i].command, directed_rows[i].entry_index,
                        directed_rows[i].start_pos, directed_rows[i].end_pos,
                        directed_rows[i].typed, directed_rows[i].want);
      end

      // Fill the low entries with wide, often overlapping exons in rising order.
      // This long stretch runs without sender gaps.
      no_gaps = 1'b1;
      for (int i = 0; i < FILL_ENTRIES; i++) begin
         s = {i[11:0], 20'($urandom_range(0, (1 << 19) - 1))};
         send_item(eoba_pkg::CMD_LOAD, IdxW'(i), s, s + 32'($urandom_range(1, 1 << 21)),
                   1'b0, NO_RESULT);
      end
      no_gaps = 1'b0;
      write_entry_count(13'(FILL_ENTRIES));
      repeat (40) send_random_item(FILL_ENTRIES);
      write_entry_count(13'(FILL_ENTRIES - 27));
      repeat (20) send_random_item(FILL_ENTRIES - 27);
      write_entry_count(13'd0);
      repeat (10) send_random_item(FILL_ENTRIES);

      // Small sorted tables, rebuilt for each phase, hold most of the random queries.
      for (int t = 0; t < NUM_SMALL_TABLES; t++) begin
         n = (t == 0) ? 1 : (t == 1) ? 2 : $urandom_range(3, 16);
         write_entry_count(13'd0);
         s = $urandom_range(0, 1 << 30);
         for (int i = 0; i < n; i++) begin
            s = s + 32'($urandom_range(0, 400));
            send_item(eoba_pkg::CMD_LOAD, IdxW'(i), s, s + 32'($urandom_range(0, 600)),
                      1'b0, NO_RESULT);
         end
         write_entry_count(13'(n));
         repeat (60) send_random_item(n);
      end

      // Drain: nothing more is sent, every expected result must still come back.
      start <= 1'b0;
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // ---------------------------------------------------------------------------------
   // Result checking and watchdog. Inputs and outputs are sampled at the rising edge,
   // before any of that edge's updates take effect.
   // ---------------------------------------------------------------------------------

   always @(posedge clock) begin
      overlap_rsp_type want;
      overlap_rsp_type got;
      if (!reset && rsp_valid) begin
         got = '{rsp_hit, rsp_hit_index, rsp_entries_updated, rsp_read_count};
         if (awaited_rsp.size() == 0) begin
            $display("%0t: unexpected result, got %h", $time, got);
            fail_count++;
         end else begin
            want = awaited_rsp.pop_front();
            if (got.hit !== want.hit) begin
               $display("%0t: hit expected %0d got %0d", $time, want.hit, got.hit);
               fail_count++;
            end
            if (got.hit_index !== want.hit_index) begin
               $display("%0t: hit_index expected %0d got %0d", $time, want.hit_index,
                        got.hit_index);
               fail_count++;
            end
            if (got.entries_updated !== want.entries_updated) begin
               $display("%0t: entries_updated expected %0d got %0d", $time,
                        want.entries_updated, got.entries_updated);
               fail_count++;
            end
            if (got.read_count !== want.read_count) begin
               $display("%0t: read_count expected %h got %h", $time, want.read_count,
                        got.read_count);
               fail_count++;
            end
         end
      end
      if (rsp_valid || (start && !busy) || (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (!reset) begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end
endmodule

/* exon_overlap_base_accumulator.f */
hw/rtl/eoba_pkg.sv
hw/rtl/eoba_ram.sv
hw/rtl/eoba_front.sv
hw/rtl/eoba_back.sv
hw/rtl/exon_overlap_base_accumulator.sv
tb/tb_top.sv
